/* sv/mpr_pkg.sv */
// Shared types and constants for the mailbox PDU receiver.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package mpr_pkg;

  // Payload buffer depth and derived widths
  localparam int PAYLOAD_MAX = 32;
  localparam int PL_AW       = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int PL_CW       = $clog2(PAYLOAD_MAX + 1);

  // Configuration register indexes
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_REQ_CODE  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_RESP_CODE = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_EXPECTED  = 2'd2;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_MATCH     = 3'd0,
    ST_MISMATCH  = 3'd1,
    ST_BADSUM    = 3'd2,
    ST_UNHANDLED = 3'd3,
    ST_OVERSIZE  = 3'd4
  } status_t;

  // Verdict of one PDU, handed from front to back
  typedef struct packed {
    logic        is_echo;
    status_t     status;
    logic [7:0]  len;
    logic [7:0]  code;
  } cmd_t;

  // Payload buffer write port driven by the front
  typedef struct packed {
    logic             we;
    logic [PL_AW-1:0] addr;
    logic [7:0]       data;
  } pl_wr_t;

  // Back status towards the front
  typedef struct packed {
    logic echo_done;
  } back_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TYPE,
    BK_PAY,
    BK_SUM
  } bk_state_t;

endpackage

`default_nettype wire

/* sv/mailbox_pdu_receiver.sv */
// Mailbox PDU receiver: one octet per cycle in; a status report or echo reply out.
// A verdict reaches the output via the command queue and the output register.
// Throughput: one octet in per cycle; an echo reply of length+3 words leaves at one word
// per cycle when unstalled; input held until the reply ends or while two verdicts wait.
// Reset: synchronous active-low rst_n resets control state and config; no clearing pass.
// Depends on mpr_pkg, mpr_front, mpr_queue and mpr_back.
`default_nettype none

module mailbox_pdu_receiver (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 in_rx_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_kind,
  output logic [7:0]                      out_reply_byte,
  output logic [2:0]                      out_status,
  output logic                            out_last,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [mpr_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [63:0]                cfg_data
);

  logic                 q_full;
  logic                 q_push;
  logic                 q_valid;
  logic                 q_pop;
  mpr_pkg::cmd_t        push_cmd;
  mpr_pkg::cmd_t        head_cmd;
  mpr_pkg::pl_wr_t      pl_wr;
  mpr_pkg::back_stat_t  bk_stat;

  // Config writes are taken in any cycle
  assign cfg_ready = 1'b1;

  mpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .pl_wr      (pl_wr),
    .bk_stat    (bk_stat)
  );

  mpr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (q_pop),
    .q_cmd    (head_cmd)
  );

  mpr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (head_cmd),
    .q_pop          (q_pop),
    .pl_wr          (pl_wr),
    .bk_stat        (bk_stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_reply_byte (out_reply_byte),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

/* sv/mpr_queue.sv */
// Short command queue between the deframing front and the result back end.
// Depends on mpr_pkg for the command type and depth.
`default_nettype none

module mpr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mpr_pkg::cmd_t push_cmd,
  output logic               full,
  output logic               q_valid,
  input  wire logic          pop,
  output mpr_pkg::cmd_t      q_cmd
);

  mpr_pkg::cmd_t                 slot_r [mpr_pkg::Q_DEPTH];
  logic [mpr_pkg::Q_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mpr_pkg::Q_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mpr_pkg::Q_CW-1:0]      count_r, count_nxt;

  assign full    = (count_r == mpr_pkg::Q_CW'(mpr_pkg::Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = slot_r[rd_ptr_r];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mpr_pkg::Q_AW'(mpr_pkg::Q_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mpr_pkg::Q_AW'(mpr_pkg::Q_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold command words
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* sv/mpr_front.sv */
// Front end: configuration registers, PDU deframing, checksum and echo compare.
// Depends on mpr_pkg; feeds mpr_queue with verdicts and the back end with payload writes.
`default_nettype none

module mpr_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_rx_byte,
  input  wire logic                          cfg_valid,
  input  wire logic [mpr_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [63:0]                   cfg_data,
  input  wire logic                          q_full,
  output logic                               q_push,
  output mpr_pkg::cmd_t                      q_cmd,
  output mpr_pkg::pl_wr_t                    pl_wr,
  input  wire mpr_pkg::back_stat_t           bk_stat
);

  logic [7:0]  req_code_r, resp_code_r;
  logic [63:0] expected_r;

  logic [8:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [7:0]  frame_type_r, frame_type_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic        echo_mismatch_r, echo_mismatch_nxt;
  logic        echo_pend_r, echo_pend_nxt;

  logic        accept;
  logic        in_payload;
  logic        is_sum_byte;
  logic [8:0]  pay_pos;
  logic [63:0] exp_shift;
  logic [7:0]  want;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_code_r  <= 8'd1;
      resp_code_r <= 8'd2;
      expected_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mpr_pkg::CFG_REQ_CODE:  req_code_r  <= cfg_data[7:0];
        mpr_pkg::CFG_RESP_CODE: resp_code_r <= cfg_data[7:0];
        mpr_pkg::CFG_EXPECTED:  expected_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold input while an echo reply is outstanding
  assign in_ready = !q_full && !echo_pend_r;
  assign accept   = in_valid && in_ready;

  assign in_payload  = (byte_index_r > 9'd1) &&
                       (byte_index_r < ({1'b0, frame_length_r} + 9'd2));
  assign is_sum_byte = (byte_index_r > 9'd1) && !in_payload;
  assign pay_pos     = byte_index_r - 9'd2;

  // Expected octet for this payload position
  assign exp_shift = expected_r >> {pay_pos[2:0], 3'b000};
  assign want      = (pay_pos < 9'd8) ? exp_shift[7:0] : 8'd0;

  // Payload buffer write
  always_comb begin
    pl_wr.we   = accept && in_payload &&
                 (frame_length_r <= 8'(mpr_pkg::PAYLOAD_MAX)) &&
                 (pay_pos < 9'(mpr_pkg::PAYLOAD_MAX));
    pl_wr.addr = pay_pos[mpr_pkg::PL_AW-1:0];
    pl_wr.data = in_rx_byte;
  end

  // Judge the PDU on the checksum word
  always_comb begin
    q_push       = accept && is_sum_byte;
    q_cmd.is_echo = 1'b0;
    q_cmd.len    = frame_length_r;
    q_cmd.code   = resp_code_r;
    if (frame_length_r > 8'(mpr_pkg::PAYLOAD_MAX)) begin
      q_cmd.status = mpr_pkg::ST_OVERSIZE;
    end else if (in_rx_byte != running_sum_r) begin
      q_cmd.status = mpr_pkg::ST_BADSUM;
    end else if (frame_type_r == req_code_r) begin
      q_cmd.status  = mpr_pkg::ST_MATCH;
      q_cmd.is_echo = 1'b1;
    end else if (frame_type_r == resp_code_r) begin
      q_cmd.status = echo_mismatch_r ? mpr_pkg::ST_MISMATCH : mpr_pkg::ST_MATCH;
    end else begin
      q_cmd.status = mpr_pkg::ST_UNHANDLED;
    end
  end

  // Advance the deframer
  always_comb begin
    byte_index_nxt    = byte_index_r;
    frame_length_nxt  = frame_length_r;
    frame_type_nxt    = frame_type_r;
    running_sum_nxt   = running_sum_r;
    echo_mismatch_nxt = echo_mismatch_r;
    echo_pend_nxt     = echo_pend_r;
    if (bk_stat.echo_done) begin
      echo_pend_nxt = 1'b0;
    end
    if (accept) begin
      if (byte_index_r == 9'd0) begin
        frame_length_nxt  = in_rx_byte;
        running_sum_nxt   = in_rx_byte;
        echo_mismatch_nxt = 1'b0;
        byte_index_nxt    = 9'd1;
      end else if (byte_index_r == 9'd1) begin
        frame_type_nxt  = in_rx_byte;
        running_sum_nxt = running_sum_r + in_rx_byte;
        byte_index_nxt  = 9'd2;
      end else if (in_payload) begin
        if (in_rx_byte != want) begin
          echo_mismatch_nxt = 1'b1;
        end
        running_sum_nxt = running_sum_r + in_rx_byte;
        byte_index_nxt  = byte_index_r + 9'd1;
      end else begin
        byte_index_nxt = 9'd0;
        if (q_cmd.is_echo) begin
          echo_pend_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r    <= '0;
      frame_length_r  <= '0;
      frame_type_r    <= '0;
      running_sum_r   <= '0;
      echo_mismatch_r <= 1'b0;
      echo_pend_r     <= 1'b0;
    end else begin
      byte_index_r    <= byte_index_nxt;
      frame_length_r  <= frame_length_nxt;
      frame_type_r    <= frame_type_nxt;
      running_sum_r   <= running_sum_nxt;
      echo_mismatch_r <= echo_mismatch_nxt;
      echo_pend_r     <= echo_pend_nxt;
    end
  end

  // An outstanding echo reply blocks the input
  a_echo_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    echo_pend_r |-> !in_ready)
    else $error("input open while echo reply outstanding");

  // Position never runs past the checksum word
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_index_r > 9'd1) |-> (byte_index_r <= ({1'b0, frame_length_r} + 9'd2)))
    else $error("byte index beyond end of PDU");

  // The checksum word closes the PDU
  a_sum_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_sum_byte) |=> (byte_index_r == 9'd0))
    else $error("deframer did not return to length word");

endmodule

`default_nettype wire

/* sv/mpr_back.sv */
// Back end: payload buffer, reply sequencer and output register.
// Depends on mpr_pkg; takes verdicts from mpr_queue and payload writes from mpr_front.
`default_nettype none

module mpr_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire mpr_pkg::cmd_t         q_cmd,
  output logic                       q_pop,
  input  wire mpr_pkg::pl_wr_t       pl_wr,
  output mpr_pkg::back_stat_t        bk_stat,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_kind,
  output logic [7:0]                 out_reply_byte,
  output logic [2:0]                 out_status,
  output logic                       out_last
);

  logic [7:0]                pl_mem_r [mpr_pkg::PAYLOAD_MAX];
  logic [7:0]                pl_q_r;
  logic [mpr_pkg::PL_AW-1:0] rd_addr;

  mpr_pkg::bk_state_t        st_r, st_nxt;
  logic [7:0]                len_r, len_nxt;
  logic [7:0]                code_r, code_nxt;
  logic [7:0]                sum_r, sum_nxt;
  logic [mpr_pkg::PL_CW-1:0] cnt_r, cnt_nxt, cnt_inc;

  logic                      out_valid_r;
  logic                      out_kind_r;
  logic [7:0]                out_byte_r;
  mpr_pkg::status_t          out_status_r;
  logic                      out_last_r;

  logic                      slot_free;
  logic                      load;
  logic                      o_kind;
  logic [7:0]                o_byte;
  mpr_pkg::status_t          o_status;
  logic                      o_last;

  assign slot_free = !out_valid_r || out_ready;
  assign cnt_inc   = cnt_r + 1'b1;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mpr_pkg::BK_IDLE:
        if (q_valid && slot_free && q_cmd.is_echo) st_nxt = mpr_pkg::BK_TYPE;
      mpr_pkg::BK_TYPE:
        if (slot_free) st_nxt = (len_r == 8'd0) ? mpr_pkg::BK_SUM : mpr_pkg::BK_PAY;
      mpr_pkg::BK_PAY:
        if (slot_free && (cnt_inc == mpr_pkg::PL_CW'(len_r))) st_nxt = mpr_pkg::BK_SUM;
      mpr_pkg::BK_SUM:
        if (slot_free) st_nxt = mpr_pkg::BK_IDLE;
      default: st_nxt = mpr_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    load              = 1'b0;
    q_pop             = 1'b0;
    o_kind            = 1'b0;
    o_byte            = 8'd0;
    o_status          = mpr_pkg::ST_MATCH;
    o_last            = 1'b0;
    len_nxt           = len_r;
    code_nxt          = code_r;
    sum_nxt           = sum_r;
    cnt_nxt           = cnt_r;
    bk_stat.echo_done = 1'b0;
    unique case (st_r)
      mpr_pkg::BK_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          load  = 1'b1;
          if (q_cmd.is_echo) begin
            o_kind   = 1'b1;
            o_byte   = q_cmd.len;
            len_nxt  = q_cmd.len;
            code_nxt = q_cmd.code;
            sum_nxt  = q_cmd.len;
          end else begin
            o_status = q_cmd.status;
            o_last   = 1'b1;
          end
        end
      end
      mpr_pkg::BK_TYPE: begin
        if (slot_free) begin
          load    = 1'b1;
          o_kind  = 1'b1;
          o_byte  = code_r;
          sum_nxt = sum_r + code_r;
          cnt_nxt = '0;
        end
      end
      mpr_pkg::BK_PAY: begin
        if (slot_free) begin
          load    = 1'b1;
          o_kind  = 1'b1;
          o_byte  = pl_q_r;
          sum_nxt = sum_r + pl_q_r;
          cnt_nxt = cnt_inc;
        end
      end
      mpr_pkg::BK_SUM: begin
        if (slot_free) begin
          load              = 1'b1;
          o_kind            = 1'b1;
          o_byte            = sum_r;
          o_last            = 1'b1;
          bk_stat.echo_done = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mpr_pkg::BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    code_r <= code_nxt;
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
  end

  // Payload buffer: one write port, one registered read port that tracks the count
  assign rd_addr = (cnt_nxt < mpr_pkg::PL_CW'(mpr_pkg::PAYLOAD_MAX))
                   ? cnt_nxt[mpr_pkg::PL_AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (pl_wr.we) begin
      pl_mem_r[pl_wr.addr] <= pl_wr.data;
    end
    pl_q_r <= pl_mem_r[rd_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r   <= o_kind;
      out_byte_r   <= o_byte;
      out_status_r <= o_status;
      out_last_r   <= o_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_reply_byte = out_byte_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

  // No new verdict is taken mid-reply
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != mpr_pkg::BK_IDLE) |-> !q_pop)
    else $error("queue popped during reply");

  // Reply words carry no status
  a_reply_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r) |-> (out_status_r == mpr_pkg::ST_MATCH))
    else $error("reply word with non-zero status");

  // A status report is always the last word of its run
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_kind_r) |-> out_last_r)
    else $error("status report without last");

  // Releasing the front ends the reply
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.echo_done |=> (st_r == mpr_pkg::BK_IDLE))
    else $error("echo done while reply continues");

endmodule

`default_nettype wire

/* tb/mpr_reply_checker.sv */
`timescale 1ns / 1ps
// Reply checker for the mailbox PDU receiver: follows PDU framing on the octet channel,
// predicts every reply and status word and compares the result channel against them.
// Depends on mpr_pkg for register indexes, status codes and the payload depth.
module mpr_reply_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [7:0]                 in_rx_byte,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_kind,
  input  logic [7:0]                 out_reply_byte,
  input  logic [2:0]                 out_status,
  input  logic                       out_last,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [mpr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [63:0]                cfg_data,
  output int                         mismatches,
  output int                         words_due
);

  typedef struct packed {
    logic             kind;
    logic [7:0]       octet;
    mpr_pkg::status_t status;
    logic             last;
  } tx_word_t;

  // Words still owed by the block, oldest first
  tx_word_t   due_q[$];

  // Register copies
  logic [7:0]  req_code;
  logic [7:0]  resp_code;
  logic [63:0] echo_pattern;

  // Deframer copy
  logic [8:0]  frame_pos;
  logic [7:0]  frame_len;
  logic [7:0]  frame_typ;
  logic [7:0]  run_sum;
  logic        echo_bad;
  logic [7:0]  pl_mem [mpr_pkg::PAYLOAD_MAX];

  function automatic void queue_word(logic kind, logic [7:0] octet, mpr_pkg::status_t st,
                                     logic last);
    tx_word_t w;
    w.kind   = kind;
    w.octet  = octet;
    w.status = st;
    w.last   = last;
    due_q.push_back(w);
  endfunction

  // Advance the deframer by one octet and queue whatever the PDU owes
  function automatic void absorb_octet(logic [7:0] b);
    int unsigned p;
    logic [7:0]  want;
    logic [7:0]  csum;
    if (frame_pos == 9'd0) begin
      frame_len = b;
      run_sum   = b;
      echo_bad  = 1'b0;
      frame_pos = 9'd1;
    end else if (frame_pos == 9'd1) begin
      frame_typ = b;
      run_sum   = run_sum + b;
      frame_pos = 9'd2;
    end else if (frame_pos < {1'b0, frame_len} + 9'd2) begin
      p = frame_pos - 9'd2;
      // oversize payloads are counted but never stored
      if (frame_len <= mpr_pkg::PAYLOAD_MAX && p < mpr_pkg::PAYLOAD_MAX) pl_mem[p] = b;
      if (p < 8) want = echo_pattern[8*p +: 8];
      else want = 8'h00;
      if (b != want) echo_bad = 1'b1;
      run_sum   = run_sum + b;
      frame_pos = frame_pos + 9'd1;
    end else begin
      // checksum octet: judge the PDU
      frame_pos = 9'd0;
      if (frame_len > mpr_pkg::PAYLOAD_MAX) begin
        queue_word(1'b0, 8'h00, mpr_pkg::ST_OVERSIZE, 1'b1);
      end else if (b != run_sum) begin
        queue_word(1'b0, 8'h00, mpr_pkg::ST_BADSUM, 1'b1);
      end else if (frame_typ == req_code) begin
        csum = frame_len + resp_code;
        queue_word(1'b1, frame_len, mpr_pkg::ST_MATCH, 1'b0);
        queue_word(1'b1, resp_code, mpr_pkg::ST_MATCH, 1'b0);
        for (int i = 0; i < frame_len; i++) begin
          csum = csum + pl_mem[i];
          queue_word(1'b1, pl_mem[i], mpr_pkg::ST_MATCH, 1'b0);
        end
        queue_word(1'b1, csum, mpr_pkg::ST_MATCH, 1'b1);
      end else if (frame_typ == resp_code) begin
        queue_word(1'b0, 8'h00, echo_bad ? mpr_pkg::ST_MISMATCH : mpr_pkg::ST_MATCH, 1'b1);
      end else begin
        queue_word(1'b0, 8'h00, mpr_pkg::ST_UNHANDLED, 1'b1);
      end
    end
  endfunction

  // Compare the word on the result channel with the oldest one owed
  function automatic void check_word();
    tx_word_t want;
    if (due_q.size() == 0) begin
      $error("unexpected word: kind %0d reply_byte %0h status %0d last %0d",
             out_kind, out_reply_byte, out_status, out_last);
      mismatches++;
    end else begin
      want = due_q.pop_front();
      if (out_kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, out_kind);
        mismatches++;
      end
      if (out_reply_byte !== want.octet) begin
        $error("reply_byte: expected %0h, got %0h", want.octet, out_reply_byte);
        mismatches++;
      end
      if (out_status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_status);
        mismatches++;
      end
      if (out_last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, out_last);
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      req_code     = 8'd1;
      resp_code    = 8'd2;
      echo_pattern = 64'd0;
      frame_pos    = 9'd0;
      frame_len    = 8'd0;
      frame_typ    = 8'd0;
      run_sum      = 8'd0;
      echo_bad     = 1'b0;
      for (int i = 0; i < mpr_pkg::PAYLOAD_MAX; i++) pl_mem[i] = 8'h00;
      due_q.delete();
      mismatches   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mpr_pkg::CFG_REQ_CODE:  req_code = cfg_data[7:0];
          mpr_pkg::CFG_RESP_CODE: resp_code = cfg_data[7:0];
          mpr_pkg::CFG_EXPECTED:  echo_pattern = cfg_data;
          default: ;  // unknown index: drop the write
        endcase
      end
      if (in_valid && in_ready) absorb_octet(in_rx_byte);
      if (out_valid && out_ready) check_word();
    end
    words_due = due_q.size();
  end

endmodule

/* tb/tb_mailbox_pdu_receiver.sv */
`timescale 1ns / 1ps
// Top of the mailbox PDU receiver testbench: clock, reset, PDU and register stimulus,
// result back-pressure and the verdict. Depends on mpr_pkg, mpr_reply_checker and the RTL.
module tb_mailbox_pdu_receiver;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [mpr_pkg::CFG_IW-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    PL_RANDOM,
    PL_ONES,
    PL_PATTERN,
    PL_SPOILED
  } fill_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [7:0]                 in_rx_byte;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_kind;
  logic [7:0]                 out_reply_byte;
  logic [2:0]                 out_status;
  logic                       out_last;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [mpr_pkg::CFG_IW-1:0] cfg_index;
  logic [63:0]                cfg_data;

  int          mismatches;
  int          words_due;
  int          cycles;
  int          octets_sent;
  int          phase_end;
  bit          sender_gaps;
  bit          receiver_gaps;
  int          stall_left;
  logic [7:0]  cur_req;
  logic [7:0]  cur_resp;
  logic [63:0] cur_pattern;
  logic [7:0]  pick_len;
  logic [7:0]  pick_typ;
  fill_t       pick_fill;
  int          roll;

  mailbox_pdu_receiver DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_reply_byte (out_reply_byte),
    .out_status     (out_status),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  mpr_reply_checker u_reply_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_reply_byte (out_reply_byte),
    .out_status     (out_status),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .words_due      (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("mailbox_pdu_receiver regression: fail");
      $finish;
    end
  end

  // Back-pressure: random stall bursts between ready stretches
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready  = 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready = 1'b1;
        if (receiver_gaps && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 8);
      end
    end
  end

  // Offer one word and hold it until taken; optionally idle first
  task automatic push_octet(input logic [7:0] b);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    octets_sent++;
    @(negedge clk);
  endtask

  // Drain every owed word, then let the pipeline settle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mpr_pkg::CFG_IW-1:0] idx, input logic [63:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reprogram all three registers; upper bits of the code writes are noise
  task automatic set_codes(input logic [7:0] req, input logic [7:0] resp,
                           input logic [63:0] pat);
    wait_idle();
    write_reg(mpr_pkg::CFG_REQ_CODE, {$urandom, 24'($urandom_range(0, 16777215)), req});
    write_reg(mpr_pkg::CFG_RESP_CODE, {$urandom, 24'($urandom_range(0, 16777215)), resp});
    write_reg(mpr_pkg::CFG_EXPECTED, pat);
    cur_req     = req;
    cur_resp    = resp;
    cur_pattern = pat;
  endtask

  // Send one PDU; at payload position pause_at, drain and flip the expected pattern
  task automatic send_pdu(input logic [7:0] len, input logic [7:0] typ, input fill_t fill,
                          input bit good_sum, input int pause_at);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] delta;
    int         spoil_at;
    sum      = len + typ;
    spoil_at = (len == 0) ? 0 : $urandom_range(0, len - 1);
    push_octet(len);
    push_octet(typ);
    for (int i = 0; i < len; i++) begin
      if (i == pause_at) begin
        wait_idle();
        cur_pattern = ~cur_pattern;
        write_reg(mpr_pkg::CFG_EXPECTED, cur_pattern);
      end
      case (fill)
        PL_ONES:  b = 8'hFF;
        PL_RANDOM: b = 8'($urandom);
        default:  b = (i < 8) ? cur_pattern[8*i +: 8] : 8'h00;
      endcase
      if (fill == PL_SPOILED && i == spoil_at) b = b ^ (8'h01 << $urandom_range(0, 7));
      sum = sum + b;
      push_octet(b);
    end
    delta = 8'($urandom_range(1, 255));
    push_octet(good_sum ? sum : sum + delta);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_rx_byte    = 8'h00;
    cfg_valid     = 1'b0;
    cfg_index     = mpr_pkg::CFG_REQ_CODE;
    cfg_data      = 64'd0;
    octets_sent   = 0;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    cur_req       = 8'd1;
    cur_resp      = 8'd2;
    cur_pattern   = 64'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset codes, every verdict, zero and full lengths, oversize
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    send_pdu(8'd0, cur_req, PL_RANDOM, 1'b1, -1);
    send_pdu(8'd0, cur_resp, PL_RANDOM, 1'b1, -1);
    send_pdu(8'd3, cur_req, PL_RANDOM, 1'b1, -1);
    send_pdu(8'd10, cur_resp, PL_PATTERN, 1'b1, -1);
    send_pdu(8'd4, cur_resp, PL_SPOILED, 1'b1, -1);
    send_pdu(8'd2, cur_req, PL_RANDOM, 1'b0, -1);
    send_pdu(8'd1, 8'hFF, PL_ONES, 1'b1, -1);
    send_pdu(8'd33, cur_req, PL_RANDOM, 1'b0, -1);
    send_pdu(8'd32, cur_req, PL_ONES, 1'b1, -1);
    // equal codes: request wins
    set_codes(8'h5A, 8'h5A, 64'h0123_4567_89AB_CDEF);
    send_pdu(8'd1, 8'h5A, PL_RANDOM, 1'b1, -1);
    set_codes(8'h00, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pdu(8'd8, 8'hFF, PL_PATTERN, 1'b1, -1);
    send_pdu(8'd0, 8'h00, PL_RANDOM, 1'b1, -1);
    // expected pattern rewritten partway through a response
    send_pdu(8'd6, 8'hFF, PL_PATTERN, 1'b1, 3);

    // Random phases; the last one runs with no idling on either side
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_codes(8'd1, 8'd2, {$urandom, $urandom});
        1: set_codes(8'hFF, 8'h00, 64'd0);
        2: set_codes(8'($urandom), 8'($urandom), {$urandom, $urandom});
        default: begin
          roll = $urandom_range(1, 255);
          set_codes(roll[7:0] ^ 8'hA5, 8'hA5, {$urandom, $urandom});
        end
      endcase
      sender_gaps   = (ph != 3);
      receiver_gaps = (ph != 3);
      phase_end = octets_sent + 68;
      while (octets_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) pick_len = 8'($urandom_range(0, 12));
        else if (roll < 93) pick_len = 8'($urandom_range(13, mpr_pkg::PAYLOAD_MAX));
        else pick_len = 8'($urandom_range(mpr_pkg::PAYLOAD_MAX + 1, 40));
        roll = $urandom_range(0, 99);
        if (roll < 40) pick_typ = cur_req;
        else if (roll < 80) pick_typ = cur_resp;
        else pick_typ = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (pick_typ == cur_resp && pick_typ != cur_req) begin
          if (roll < 60) pick_fill = PL_PATTERN;
          else if (roll < 85) pick_fill = PL_SPOILED;
          else pick_fill = PL_RANDOM;
        end else begin
          pick_fill = (roll < 10) ? PL_ONES : PL_RANDOM;
        end
        send_pdu(pick_len, pick_typ, pick_fill, $urandom_range(0, 9) != 0, -1);
      end
    end

    // Drain and give the verdict
    in_valid = 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && words_due == 0) begin
      $display("mailbox_pdu_receiver regression: pass");
    end else begin
      $display("mailbox_pdu_receiver regression: fail");
    end
    $finish;
  end

endmodule
